[sv/mvm_pkg.sv]
// Shared types and constants for the integer matrix-vector multiply block.
// Holds the request and response item structs, command codes and pipeline tag.
// No dependencies.
package mvm_pkg;

   // Width of the entry values and of the index fields.
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned INDEX_W = 4;
   localparam int unsigned SIZE_W  = 5;

   // Command codes carried in the cmd field of a request item.
   localparam logic [1:0] CMD_WRITE_MATRIX = 2'd0;
   localparam logic [1:0] CMD_WRITE_VECTOR = 2'd1;
   localparam logic [1:0] CMD_COMPUTE      = 2'd2;

   // Size register value after reset.
   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   // One request item.
   typedef struct packed {
      logic [1:0]                cmd;
      logic [INDEX_W-1:0]        row_index;
      logic [INDEX_W-1:0]        col_index;
      logic signed [DATA_W-1:0]  entry_value;
   } mvm_req_type;

   // One response item.
   typedef struct packed {
      logic [INDEX_W-1:0]        result_row;
      logic signed [DATA_W-1:0]  result_value;
      logic                      last_row;
   } mvm_rsp_type;

   // Control tag that travels with each store read through the datapath.
   typedef struct packed {
      logic               valid;
      logic               last_col;
      logic               last_row;
      logic [INDEX_W-1:0] row;
   } mvm_tag_type;

endpackage

[sv/mvm_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the matrix and vector stores. No dependencies.
module mvm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; no reset on the array.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/mvm_mac.sv]
// Multiply-accumulate datapath: registered product, then a running row sum.
// Depends on mvm_pkg for the pipeline tag type.
module mvm_mac (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  mvm_pkg::mvm_tag_type         tag_in,
   input  logic [mvm_pkg::DATA_W-1:0]   matrix_data,
   input  logic [mvm_pkg::DATA_W-1:0]   vector_data,
   output logic                         busy,
   output logic                         row_done,
   output mvm_pkg::mvm_tag_type         done_tag,
   output logic [mvm_pkg::DATA_W-1:0]   row_sum
);
   import mvm_pkg::*;

   mvm_tag_type         prod_tag_ff;
   logic [DATA_W-1:0]   prod_ff;
   logic [DATA_W-1:0]   acc_ff;
   logic [DATA_W-1:0]   sum;
   logic [DATA_W-1:0]   full_prod;

   // Only the low half of the product is kept; it is the same for signed and
   // unsigned operands.
   assign full_prod = matrix_data * vector_data;
   assign sum       = acc_ff + prod_ff;

   // Product stage and accumulator; the sum clears after the last column.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_tag_ff <= '0;
         acc_ff      <= '0;
      end else if (advance) begin
         prod_tag_ff <= tag_in;
         if (prod_tag_ff.valid) begin
            acc_ff <= prod_tag_ff.last_col ? '0 : sum;
         end
      end
      if (advance) begin
         prod_ff <= full_prod;
      end
   end

   assign busy     = prod_tag_ff.valid;
   assign row_done = advance && prod_tag_ff.valid && prod_tag_ff.last_col;
   assign done_tag = prod_tag_ff;
   assign row_sum  = sum;

endmodule

[sv/matrix_vector_multiply.sv]
// Top level of the integer matrix-vector multiply block: stores, sequencer
// and output register. Depends on mvm_pkg, mvm_ram and mvm_mac.
//
// Usage:
// Request items arrive on req_valid/req_ready with an mvm_req_type payload.
// A matrix or vector write item is written to its store as it is accepted,
// so writes stream at one item per cycle while the block is idle. A compute
// item walks the stores row by row with one multiply-accumulate per cycle
// while the output is not stalled, up to the size in use, which is the size
// register capped at MAX_SIZE and 16; no request item is taken while the walk
// or a product is in flight. Results leave the output register one per row,
// in row order, and the last result of a run carries last_row. A compute item
// with size zero produces nothing. The size register is written through
// csr_wr_en/csr_wr_data.
// When the receiver holds rsp_ready low, the whole read pipeline freezes
// with the pending result held in the output register.
// Reset clears the control state and sets the size to 16; the stores hold
// no defined value until written.
module matrix_vector_multiply #(
   parameter int unsigned MAX_SIZE = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  mvm_pkg::mvm_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output mvm_pkg::mvm_rsp_type           rsp_data,
   input  logic                           csr_wr_en,
   input  logic [mvm_pkg::SIZE_W-1:0]     csr_wr_data
);
   import mvm_pkg::*;

   localparam int unsigned CAP    = (MAX_SIZE < 16) ? MAX_SIZE : 16;
   localparam int unsigned CW     = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int unsigned IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int unsigned MDEPTH = MAX_SIZE * MAX_SIZE;
   localparam int unsigned MA_W   = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

   // Issue stage: the store address currently being read.
   typedef struct packed {
      logic          valid;
      logic [CW-1:0] row;
      logic [CW-1:0] col;
   } iss_type;

   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] n_eff;
   iss_type           iss_ff;
   iss_type           iss_in;
   logic              rsp_valid_ff;
   mvm_rsp_type       rsp_data_ff;

   logic              advance;
   logic              req_take;
   logic              mac_busy;
   logic              row_done;
   mvm_tag_type       done_tag;
   mvm_tag_type       tag;
   logic [DATA_W-1:0] row_sum;

   logic              m_wr_en;
   logic [MA_W-1:0]   m_wr_addr;
   logic [MA_W-1:0]   m_rd_addr;
   logic [DATA_W-1:0] m_rd_data;
   logic              v_wr_en;
   logic [IDX_W-1:0]  v_wr_addr;
   logic [IDX_W-1:0]  v_rd_addr;
   logic [DATA_W-1:0] v_rd_data;
   logic              is_last_col;
   logic              is_last_row;

   // Size register and its capped value.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   assign n_eff = (size_ff > SIZE_W'(CAP)) ? SIZE_W'(CAP) : size_ff;

   // The pipeline moves whenever the output register can take a result.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !iss_ff.valid && !mac_busy;
   assign req_take  = req_valid && req_ready;

   // Store writes happen as the write item is accepted.
   always_comb begin
      m_wr_en   = 1'b0;
      v_wr_en   = 1'b0;
      m_wr_addr = MA_W'(int'(req_data.row_index) * MAX_SIZE + int'(req_data.col_index));
      v_wr_addr = IDX_W'(req_data.col_index);
      case (req_data.cmd)
         CMD_WRITE_MATRIX: begin
            m_wr_en = req_take && (int'(req_data.row_index) < MAX_SIZE)
                      && (int'(req_data.col_index) < MAX_SIZE);
         end
         CMD_WRITE_VECTOR: begin
            v_wr_en = req_take && (int'(req_data.col_index) < MAX_SIZE);
         end
         default: begin
         end
      endcase
   end

   // Row and column comparisons against the size in use.
   assign is_last_col = (SIZE_W'(iss_ff.col) + SIZE_W'(1)) == n_eff;
   assign is_last_row = (SIZE_W'(iss_ff.row) + SIZE_W'(1)) == n_eff;

   // Next issue address: start on a compute item, then walk row-major.
   always_comb begin
      iss_in = iss_ff;
      if (req_take && (req_data.cmd == CMD_COMPUTE) && (n_eff != '0)) begin
         iss_in = '{valid: 1'b1, row: '0, col: '0};
      end else if (advance && iss_ff.valid) begin
         if (is_last_col) begin
            iss_in.col = '0;
            if (is_last_row) begin
               iss_in.valid = 1'b0;
            end else begin
               iss_in.row = iss_ff.row + CW'(1);
            end
         end else begin
            iss_in.col = iss_ff.col + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff <= '0;
      end else begin
         iss_ff <= iss_in;
      end
   end

   // Read addresses follow the next issue value so data lines up with iss_ff.
   assign m_rd_addr = MA_W'(int'(iss_in.row) * MAX_SIZE + int'(iss_in.col));
   assign v_rd_addr = IDX_W'(iss_in.col);

   mvm_ram #(.WIDTH(DATA_W), .DEPTH(MDEPTH)) u_matrix_ram (
      .clock   (clock),
      .wr_en   (m_wr_en),
      .wr_addr (m_wr_addr),
      .wr_data (req_data.entry_value),
      .rd_addr (m_rd_addr),
      .rd_data (m_rd_data)
   );

   mvm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE)) u_vector_ram (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (v_wr_addr),
      .wr_data (req_data.entry_value),
      .rd_addr (v_rd_addr),
      .rd_data (v_rd_data)
   );

   // Tag for the data now on the store outputs.
   assign tag = '{valid:    iss_ff.valid,
                  last_col: is_last_col,
                  last_row: is_last_row,
                  row:      INDEX_W'(iss_ff.row)};

   mvm_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .tag_in      (tag),
      .matrix_data (m_rd_data),
      .vector_data (v_rd_data),
      .busy        (mac_busy),
      .row_done    (row_done),
      .done_tag    (done_tag),
      .row_sum     (row_sum)
   );

   // Output register holds one finished row until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= row_done;
      end
      if (row_done) begin
         rsp_data_ff.result_row   <= done_tag.row;
         rsp_data_ff.result_value <= row_sum;
         rsp_data_ff.last_row     <= done_tag.last_row;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // No new item is taken while a product is still in flight.
   assert property (@(posedge clock) disable iff (reset) mac_busy |-> !req_ready)
      else $error("request accepted while the datapath is busy");

   // The issue counters stay inside the matrix in use.
   assert property (@(posedge clock) disable iff (reset)
      iss_ff.valid |-> (SIZE_W'(iss_ff.row) < n_eff) && (SIZE_W'(iss_ff.col) < n_eff))
      else $error("issue address beyond the size in use");

   // The flagged result is the final row of the run.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_row) |-> (SIZE_W'(rsp_data.result_row) + SIZE_W'(1) == n_eff))
      else $error("last_row flagged on a row other than the final one");

   // A compute item with a nonzero size starts the walk at row 0, column 0.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_data.cmd == CMD_COMPUTE) && (n_eff != '0))
      |=> (iss_ff.valid && (iss_ff.row == '0) && (iss_ff.col == '0)))
      else $error("compute run did not start at the first entry");

endmodule
